>>> rtl/hrlc_pkg.sv
`default_nettype none
package hrlc_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned ADDR_W    = 12;
    localparam int unsigned BYTES_W   = 4;
    localparam int unsigned LIMIT_W   = 17;
    localparam int unsigned COUNT_W   = 6;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd4096;
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 6'd63;
    localparam logic [BYTES_W-1:0] BYTES_SAT   = 4'd15;

    // register byte addresses
    localparam logic [PADDR_W-1:0] REG_MEMORY_LIMIT = 3'd0;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    typedef enum logic [1:0] {
        PH_DIGITS = 2'd0,
        PH_SPACES = 2'd1,
        PH_FAULT  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    typedef struct packed {
        logic              line_error;
        logic              has_address;
        logic [ADDR_W-1:0] address;
        logic [BYTES_W-1:0] data_bytes;
    } result_t;

    function automatic nibble_t nibble_of(input logic [CHAR_W-1:0] c);
        nibble_t n;
        n.ok    = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            n.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            n.value = 4'(c - 8'h37);
        end
        else
        begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hrlc_char_if.sv
`default_nettype none
interface hrlc_char_if;
    logic                          valid;
    logic                          ready;
    logic [hrlc_pkg::CHAR_W-1:0]   character;
    logic                          line_end;

    modport source (output valid, output character, output line_end, input ready);
    modport sink   (input valid, input character, input line_end, output ready);
endinterface
`default_nettype wire

>>> rtl/hrlc_result_if.sv
`default_nettype none
interface hrlc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          line_error;
    logic                          has_address;
    logic [hrlc_pkg::ADDR_W-1:0]   address;
    logic [hrlc_pkg::BYTES_W-1:0]  data_bytes;

    modport source (output valid, output line_error, output has_address,
                    output address, output data_bytes, input ready);
    modport sink   (input valid, input line_error, input has_address,
                    input address, input data_bytes, output ready);
endinterface
`default_nettype wire

>>> rtl/hex_record_line_checker.sv
// Hex record line checker.
// char_stream carries one character per word, line_end marks the last one
// of a line. For every line the block emits one word on result_stream:
// line_error, has_address, the three-digit address and the data byte count.
// Words without line_end produce nothing on result_stream.
// Throughput: one character per cycle while char_stream.ready is high. The column state is
// updated at the accepting edge and the line's result is registered at that
// same edge, into the main register, or the skid register if main is still held.
// The output has a main register plus a skid register: characters keep
// flowing while a result waits, and char_stream.ready drops only when both
// hold unread results (result_stream stalled across two line ends).
// memory_limit is written over the APB port at byte address 0 (reset 4096).
// Reset (rst_n low, asynchronous) returns the line state to the start of a
// line, empties both result registers and restores memory_limit.
`default_nettype none
module hex_record_line_checker #(
    parameter int unsigned DATA_START_COLUMN = 7,
    parameter int unsigned BAR_COLUMN        = 28
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    hrlc_char_if.sink                               char_stream,
    hrlc_result_if.source                           result_stream,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [hrlc_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [hrlc_pkg::PDATA_W-1:0]       pwdata,
    output logic      [hrlc_pkg::PDATA_W-1:0]       prdata,
    output logic                                    pready
);

    // the counter must also hold the data start column when it lies past the bar
    localparam int unsigned COL_TOP = (DATA_START_COLUMN > BAR_COLUMN) ?
                                      DATA_START_COLUMN : BAR_COLUMN;
    localparam int unsigned COL_W = $clog2(COL_TOP + 2);
    localparam logic [COL_W-1:0] COL_SAT  = COL_W'(BAR_COLUMN + 1);
    localparam logic [COL_W-1:0] COL_BAR  = COL_W'(BAR_COLUMN);
    localparam logic [COL_W-1:0] COL_DATA = COL_W'(DATA_START_COLUMN);

    localparam int unsigned AW = hrlc_pkg::ADDR_W;
    localparam int unsigned CW = hrlc_pkg::COUNT_W;
    localparam int unsigned LW = hrlc_pkg::LIMIT_W;

    logic [LW-1:0]      limit_reg;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               zx_ok_reg, zx_ok_next;
    logic               colon_ok_reg, colon_ok_next;
    logic               space_ok_reg, space_ok_next;
    logic               hex_ok_reg, hex_ok_next;
    logic               blank_reg, blank_next;
    hrlc_pkg::phase_t   phase_reg, phase_next;
    logic               half_reg, half_next;
    logic               bar_reg, bar_next;

    hrlc_pkg::result_t  main_reg, main_next, skid_reg, skid_next, result_now;
    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               accept, push, pop, cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == hrlc_pkg::REG_MEMORY_LIMIT) ?
                       hrlc_pkg::PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hrlc_pkg::LIMIT_RESET;
        end
        else if (cfg_write && paddr == hrlc_pkg::REG_MEMORY_LIMIT)
        begin
            limit_reg <= pwdata[LW-1:0];
        end
    end

    // ---------------- per-character update ----------------
    assign char_stream.ready = !skid_valid_reg;
    assign accept = char_stream.valid && char_stream.ready;

    always_comb
    begin
        logic [hrlc_pkg::CHAR_W-1:0] c;
        hrlc_pkg::nibble_t nib;
        logic [COL_W-1:0]  col;
        logic              is_space;

        c        = char_stream.character;
        nib      = hrlc_pkg::nibble_of(c);
        col      = column_reg;
        is_space = (c == hrlc_pkg::CH_SPACE);

        column_next   = (col < COL_SAT) ? col + COL_W'(1) : col;
        addr_next     = addr_reg;
        count_next    = count_reg;
        zx_ok_next    = zx_ok_reg;
        colon_ok_next = colon_ok_reg;
        space_ok_next = space_ok_reg;
        hex_ok_next   = hex_ok_reg;
        blank_next    = blank_reg;
        phase_next    = phase_reg;
        half_next     = half_reg;
        bar_next      = bar_reg;

        if (col < COL_BAR)
        begin
            if (!is_space)
                blank_next = 1'b0;
            if ((col == COL_W'(0) && c != hrlc_pkg::CH_ZERO) ||
                (col == COL_W'(1) && c != hrlc_pkg::CH_X))
                zx_ok_next = 1'b0;
            if (col == COL_W'(5) && c != hrlc_pkg::CH_COLON)
                colon_ok_next = 1'b0;
            if (col == COL_W'(6) && !is_space)
                space_ok_next = 1'b0;
            if (col >= COL_W'(2) && col <= COL_W'(4))
            begin
                if (!nib.ok)
                    hex_ok_next = 1'b0;
                else
                    addr_next = {addr_reg[AW-5:0], nib.value};
            end
            // gap between the address field and the data columns
            if (col >= COL_W'(7) && col < COL_DATA)
            begin
                if (!is_space)
                    phase_next = hrlc_pkg::PH_FAULT;
            end
            else if (col >= COL_DATA && phase_reg != hrlc_pkg::PH_FAULT)
            begin
                if (half_reg)
                begin
                    if (!nib.ok)
                        phase_next = hrlc_pkg::PH_FAULT;
                    else if (count_reg < hrlc_pkg::COUNT_SAT)
                        count_next = count_reg + CW'(1);
                    half_next = 1'b0;
                end
                else if (phase_reg == hrlc_pkg::PH_DIGITS)
                begin
                    if (is_space)
                        phase_next = hrlc_pkg::PH_SPACES;
                    else if (!nib.ok)
                        phase_next = hrlc_pkg::PH_FAULT;
                    else
                        half_next = 1'b1;
                end
                else if (!is_space)
                begin
                    phase_next = hrlc_pkg::PH_FAULT;
                end
            end
        end
        else if (col == COL_BAR)
        begin
            bar_next = (c == hrlc_pkg::CH_BAR);
        end
    end

    // ---------------- end-of-line result ----------------
    always_comb
    begin
        logic          addr_form;
        logic [LW-1:0] reach;

        addr_form = (column_next >= COL_W'(7)) && zx_ok_next && colon_ok_next
                    && space_ok_next;
        reach     = LW'(addr_next) + LW'(count_next);

        priority if (column_next <= COL_BAR || !bar_next)
            result_now.line_error = 1'b1;
        else if (!addr_form)
            result_now.line_error = !blank_next;
        else if (!hex_ok_next)
            result_now.line_error = 1'b1;
        else if (phase_next == hrlc_pkg::PH_FAULT || half_next)
            result_now.line_error = 1'b1;
        else if (count_next != '0 && reach > limit_reg)
            result_now.line_error = 1'b1;
        else
            result_now.line_error = 1'b0;

        result_now.has_address = addr_form;
        result_now.address     = (addr_form && hex_ok_next) ? addr_next : '0;
        if (!addr_form)
            result_now.data_bytes = '0;
        else if (count_next > CW'(hrlc_pkg::BYTES_SAT))
            result_now.data_bytes = hrlc_pkg::BYTES_SAT;
        else
            result_now.data_bytes = count_next[hrlc_pkg::BYTES_W-1:0];
    end

    // ---------------- output register and skid ----------------
    assign push = accept && char_stream.line_end;
    assign pop  = main_valid_reg && result_stream.ready;

    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = result_now;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            // main still waiting: park the new result
            skid_next       = result_now;
            skid_valid_next = 1'b1;
        end
    end

    assign result_stream.valid       = main_valid_reg;
    assign result_stream.line_error  = main_reg.line_error;
    assign result_stream.has_address = main_reg.has_address;
    assign result_stream.address     = main_reg.address;
    assign result_stream.data_bytes  = main_reg.data_bytes;

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // ---------------- line state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            addr_reg     <= '0;
            count_reg    <= '0;
            zx_ok_reg    <= 1'b1;
            colon_ok_reg <= 1'b1;
            space_ok_reg <= 1'b1;
            hex_ok_reg   <= 1'b1;
            blank_reg    <= 1'b1;
            phase_reg    <= hrlc_pkg::PH_DIGITS;
            half_reg     <= 1'b0;
            bar_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (char_stream.line_end)
            begin
                // start the next line fresh
                column_reg   <= '0;
                addr_reg     <= '0;
                count_reg    <= '0;
                zx_ok_reg    <= 1'b1;
                colon_ok_reg <= 1'b1;
                space_ok_reg <= 1'b1;
                hex_ok_reg   <= 1'b1;
                blank_reg    <= 1'b1;
                phase_reg    <= hrlc_pkg::PH_DIGITS;
                half_reg     <= 1'b0;
                bar_reg      <= 1'b0;
            end
            else
            begin
                column_reg   <= column_next;
                addr_reg     <= addr_next;
                count_reg    <= count_next;
                zx_ok_reg    <= zx_ok_next;
                colon_ok_reg <= colon_ok_next;
                space_ok_reg <= space_ok_next;
                hex_ok_reg   <= hex_ok_next;
                blank_reg    <= blank_next;
                phase_reg    <= phase_next;
                half_reg     <= half_next;
                bar_reg      <= bar_next;
            end
        end
    end

endmodule
`default_nettype wire
